@@ hdl/ptsa_pkg.sv @@
`default_nettype none
package ptsa_pkg;

    localparam int unsigned PTSA_SEC_BITS = 40;

    localparam int unsigned SEC_W       = 40;
    localparam int unsigned NSEC_W      = 30;
    localparam int unsigned USEC_W      = 20;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned CALIB_W     = 16;
    localparam int unsigned CALIB_SUM_W = 46;
    localparam int unsigned FSEC_W      = 32;
    localparam int unsigned FNSEC_W     = 31;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic signed [31:0] NS_PER_SEC  = 32'sd1000000000;
    localparam logic signed [31:0] NS_HALF_SEC = 32'sd500000000;
    localparam logic [CALIB_W-1:0] NS_PER_US   = 16'd1000;

    // ns / 1000 == (ns * USEC_RECIP) >> USEC_SHIFT, exact for ns < 2^30
    localparam int unsigned            USEC_RECIP_W = 29;
    localparam int unsigned            USEC_SHIFT   = 38;
    localparam logic [USEC_RECIP_W-1:0] USEC_RECIP  = 29'd274877907;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_PULSES = 2'd0,
        CFG_FUDGE_SEC    = 2'd1,
        CFG_FUDGE_NSEC   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              published;
        logic [SEC_W-1:0]  receive_sec;
        logic [USEC_W-1:0] receive_usec;
        logic [SEC_W-1:0]  pulse_sec;
        logic              rounded_up;
        logic [CNT_W-1:0]  round_up_total;
        logic [CNT_W-1:0]  read_total;
    } t_out_beat;

endpackage
`default_nettype wire

@@ hdl/ptsa_ifs.sv @@
`default_nettype none
interface ptsa_in_if
    import ptsa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SEC_W-1:0]  stamp_sec;
    logic [NSEC_W-1:0] stamp_nsec;
    logic              consumer_read;

    modport source (output valid, output stamp_sec, output stamp_nsec,
                    output consumer_read, input ready);
    modport sink   (input valid, input stamp_sec, input stamp_nsec,
                    input consumer_read, output ready);
endinterface

interface ptsa_out_if
    import ptsa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              published;
    logic [SEC_W-1:0]  receive_sec;
    logic [USEC_W-1:0] receive_usec;
    logic [SEC_W-1:0]  pulse_sec;
    logic              rounded_up;
    logic [CNT_W-1:0]  round_up_total;
    logic [CNT_W-1:0]  read_total;

    modport source (output valid, output published, output receive_sec,
                    output receive_usec, output pulse_sec, output rounded_up,
                    output round_up_total, output read_total, input ready);
    modport sink   (input valid, input published, input receive_sec,
                    input receive_usec, input pulse_sec, input rounded_up,
                    input round_up_total, input read_total, output ready);
endinterface
`default_nettype wire

@@ hdl/ptsa_div.sv @@
`default_nettype none
module ptsa_div
    import ptsa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [CALIB_SUM_W-1:0] i_dividend,
    input  wire logic [CALIB_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic [CALIB_SUM_W-1:0]      o_quot
);

    localparam int unsigned CW = $clog2(CALIB_SUM_W + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [CALIB_SUM_W-1:0] r_quot;
    logic [CALIB_W-1:0]     r_rem;
    logic [CALIB_W-1:0]     r_dvsr;

    logic [CALIB_W:0]       w_trial;
    logic                   w_fit;
    logic [CALIB_W-1:0]     w_rem;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quot[CALIB_SUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_dvsr});
        w_rem   = w_fit ? CALIB_W'(w_trial - {1'b0, r_dvsr}) : w_trial[CALIB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(CALIB_SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[CALIB_SUM_W-2:0], w_fit};
            r_rem  <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

@@ hdl/pps_edge_timestamp_aligner.sv @@
`default_nettype none
// PPS edge timestamp aligner. Takes one captured local time per PPS edge and
// returns one beat per edge. While calibration is enabled the first
// calib_pulses edges are summed and give unpublished beats; on the last one
// the average nanoseconds, negated, replaces the fudge registers until reset.
// Other edges get the correction, nanosecond carry/borrow normalization,
// a microsecond value and the second rounded to nearest. One edge at a time:
// a published edge passes accept, offset add, 1 to 3 normalization steps, a
// reciprocal multiply for the /1000 and output; a calibrating edge goes from
// accept and offset add to output, the final one waiting for the serial
// restoring divider to form the average. A full output register that is not
// taken adds its stall on top. The result sits in an output register, so the
// next edge is taken while it waits. Write configuration only while idle.
module pps_edge_timestamp_aligner
    import ptsa_pkg::*;
#(
    parameter int unsigned SEC_BITS = PTSA_SEC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ptsa_in_if.sink                    i_in,
    ptsa_out_if.source                 o_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADJ  = 6'b000010,
        S_NORM = 6'b000100,
        S_CDIV = 6'b001000,
        S_UDIV = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;

    logic [CALIB_W-1:0]       r_calib_pulses;
    logic signed [FSEC_W-1:0] r_fudge_sec;
    logic signed [FNSEC_W-1:0] r_fudge_nsec;

    logic [CALIB_W-1:0]        r_done_cnt;
    logic [CALIB_SUM_W-1:0]    r_calib_sum;
    logic signed [FNSEC_W-1:0] r_calib_off;
    logic                      r_calibrated;
    logic [CNT_W-1:0]          r_round_cnt;
    logic [CNT_W-1:0]          r_read_cnt;
    logic                      r_cal_item;
    logic                      r_out_valid;

    logic [SEC_BITS-1:0] r_sec;
    logic signed [31:0]  r_nsec;
    logic [USEC_W-1:0]   r_usec;
    logic                r_up;
    t_out_beat           r_out;

    logic                      w_div_start;
    logic                      w_div_done;
    logic [CALIB_SUM_W-1:0]    w_quot;
    logic [NSEC_W+USEC_RECIP_W-1:0] w_usec_prod;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_cal_now;
    logic [SEC_BITS-1:0]       w_adj_sec;
    logic signed [FNSEC_W-1:0] w_adj_nsec;
    logic                      w_norm_ok;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_cal_now   = (r_calib_pulses > r_done_cnt);
    assign w_adj_sec   = r_calibrated ? '0 : SEC_BITS'(r_fudge_sec);
    assign w_adj_nsec  = r_calibrated ? r_calib_off : r_fudge_nsec;
    assign w_norm_ok   = !r_nsec[31] && (r_nsec < NS_PER_SEC);
    assign w_div_start = (r_state == S_ADJ) && r_cal_item && (r_done_cnt == r_calib_pulses);
    assign w_usec_prod = r_nsec[NSEC_W-1:0] * USEC_RECIP;

    ptsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_calib_sum),
        .i_divisor  (r_done_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_calib_pulses <= '0;
            r_fudge_sec    <= '0;
            r_fudge_nsec   <= '0;
            r_done_cnt     <= '0;
            r_calib_sum    <= '0;
            r_calib_off    <= '0;
            r_calibrated   <= 1'b0;
            r_round_cnt    <= '0;
            r_read_cnt     <= '0;
            r_cal_item     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CALIB_PULSES: r_calib_pulses <= i_cfg_data[CALIB_W-1:0];
                    CFG_FUDGE_SEC:    r_fudge_sec    <= i_cfg_data[FSEC_W-1:0];
                    CFG_FUDGE_NSEC:   r_fudge_nsec   <= i_cfg_data[FNSEC_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_read_cnt <= r_read_cnt + CNT_W'(i_in.consumer_read);
                        r_cal_item <= w_cal_now;
                        if (w_cal_now) begin
                            r_calib_sum <= r_calib_sum + CALIB_SUM_W'(i_in.stamp_nsec);
                            r_done_cnt  <= r_done_cnt + 1'b1;
                        end
                        r_state <= S_ADJ;
                    end
                end
                S_ADJ: begin
                    if (!r_cal_item) begin
                        r_state <= S_NORM;
                    end else if (w_div_start) begin
                        r_state <= S_CDIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_NORM: begin
                    if (w_norm_ok) begin
                        if (r_nsec >= NS_HALF_SEC) begin
                            r_round_cnt <= r_round_cnt + 1'b1;
                        end
                        r_state <= S_UDIV;
                    end
                end
                S_CDIV: begin
                    if (w_div_done) begin
                        r_calib_off  <= FNSEC_W'(0) - w_quot[FNSEC_W-1:0];
                        r_calibrated <= 1'b1;
                        r_state      <= S_FIN;
                    end
                end
                S_UDIV: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sec  <= SEC_BITS'(i_in.stamp_sec);
                r_nsec <= $signed({2'b00, i_in.stamp_nsec});
            end
            S_ADJ: begin
                r_sec  <= r_sec + w_adj_sec;
                r_nsec <= r_nsec + 32'(w_adj_nsec);
            end
            S_NORM: begin
                if (r_nsec[31]) begin
                    r_nsec <= r_nsec + NS_PER_SEC;
                    r_sec  <= r_sec - 1'b1;
                end else if (r_nsec >= NS_PER_SEC) begin
                    r_nsec <= r_nsec - NS_PER_SEC;
                    r_sec  <= r_sec + 1'b1;
                end else begin
                    r_up <= (r_nsec >= NS_HALF_SEC);
                end
            end
            S_UDIV: begin
                r_usec <= w_usec_prod[USEC_SHIFT +: USEC_W];
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out.published      <= !r_cal_item;
                    r_out.receive_sec    <= r_cal_item ? '0 : SEC_W'(r_sec);
                    r_out.receive_usec   <= r_cal_item ? '0 : r_usec;
                    r_out.pulse_sec      <= r_cal_item ? '0 :
                                            SEC_W'(r_sec + SEC_BITS'(r_up));
                    r_out.rounded_up     <= !r_cal_item && r_up;
                    r_out.round_up_total <= r_round_cnt;
                    r_out.read_total     <= r_read_cnt;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.published      = r_out.published;
    assign o_out.receive_sec    = r_out.receive_sec;
    assign o_out.receive_usec   = r_out.receive_usec;
    assign o_out.pulse_sec      = r_out.pulse_sec;
    assign o_out.rounded_up     = r_out.rounded_up;
    assign o_out.round_up_total = r_out.round_up_total;
    assign o_out.read_total     = r_out.read_total;

endmodule
`default_nettype wire

@@ dv/pps_edge_timestamp_aligner_test.sv @@
`timescale 1ns / 1ps
module pps_edge_timestamp_aligner_test;
    import ptsa_pkg::*;

    localparam logic [SEC_W-1:0]  SEC_TOP     = {SEC_W{1'b1}};
    localparam logic [NSEC_W-1:0] NSEC_TOP    = {NSEC_W{1'b1}};
    localparam int                STALL_LIMIT = 4000;
    localparam int                HOLD_LEN    = 800;
    localparam int                NUM_PHASES  = 14;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
        logic              consumer_read;
    } t_pulse;

    typedef enum logic {ROW_CFG, ROW_PULSE} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [CALIB_W-1:0]  calib;
        logic [FSEC_W-1:0]   fsec;
        logic [31:0]         fnsec;
        t_pulse              pulse;
        logic                known;
        t_out_beat           want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptsa_in_if  in_if ();
    ptsa_out_if out_if ();

    pps_edge_timestamp_aligner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor copy of config and state
    logic [CALIB_W-1:0]         cal_target = '0;
    logic signed [FSEC_W-1:0]   trim_sec   = '0;
    logic signed [FNSEC_W-1:0]  trim_nsec  = '0;
    logic [CALIB_W-1:0]         cal_count  = '0;
    logic [CALIB_SUM_W-1:0]     cal_acc    = '0;
    logic signed [FNSEC_W-1:0]  cal_trim   = '0;
    logic                       cal_locked = 1'b0;
    logic [CNT_W-1:0]           up_cnt     = '0;
    logic [CNT_W-1:0]           rd_cnt     = '0;

    t_out_beat  aligned_q[$];
    t_plan_row  plan[$];
    int         bad_fields  = 0;
    int         beat_idx    = 0;
    int         quiet_cycles = 0;
    int         hold_len    = 0;
    bit         idle_on     = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_beat align_pulse(input t_pulse p);
        t_out_beat        r;
        longint           ns;
        longint           add_s;
        longint           add_ns;
        longint           avg;
        logic [SEC_W-1:0] s;
        logic             up;
        r = '0;
        rd_cnt = rd_cnt + CNT_W'(p.consumer_read);
        if (cal_target > cal_count) begin
            cal_acc = cal_acc + CALIB_SUM_W'(p.nsec);
            cal_count = cal_count + 1'b1;
            if (cal_count == cal_target && cal_count != '0) begin
                avg = cal_acc / cal_count;
                cal_trim = FNSEC_W'(-avg);
                cal_locked = 1'b1;
            end
            r.round_up_total = up_cnt;
            r.read_total = rd_cnt;
            return r;
        end
        add_s  = cal_locked ? 64'sd0 : longint'(trim_sec);
        add_ns = cal_locked ? longint'(cal_trim) : longint'(trim_nsec);
        s  = p.sec + add_s[SEC_W-1:0];
        ns = longint'(p.nsec);
        ns = ns + add_ns;
        while (ns < 0) begin
            ns = ns + NS_PER_SEC;
            s  = s - 1'b1;
        end
        while (ns >= NS_PER_SEC) begin
            ns = ns - NS_PER_SEC;
            s  = s + 1'b1;
        end
        up = (ns >= NS_HALF_SEC);
        if (up) begin
            up_cnt = up_cnt + 1'b1;
        end
        r.published      = 1'b1;
        r.receive_sec    = s;
        r.receive_usec   = USEC_W'(ns / NS_PER_US);
        r.pulse_sec      = s + SEC_W'(up);
        r.rounded_up     = up;
        r.round_up_total = up_cnt;
        r.read_total     = rd_cnt;
        return r;
    endfunction

    function automatic void plan_cfg(input logic [CALIB_W-1:0] cp,
                                     input logic signed [31:0] fs,
                                     input logic signed [31:0] fn);
        t_plan_row row;
        row = '{kind: ROW_CFG, calib: cp, fsec: fs, fnsec: fn, pulse: '0,
                known: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_pulse(input logic [SEC_W-1:0] s,
                                       input logic [NSEC_W-1:0] ns, input logic rd);
        t_plan_row row;
        row = '{kind: ROW_PULSE, calib: '0, fsec: '0, fnsec: '0,
                pulse: '{sec: s, nsec: ns, consumer_read: rd}, known: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_known(input logic [SEC_W-1:0] s,
                                       input logic [NSEC_W-1:0] ns, input logic rd,
                                       input logic [SEC_W-1:0] rsec,
                                       input logic [USEC_W-1:0] usec,
                                       input logic [SEC_W-1:0] psec, input logic up,
                                       input logic [CNT_W-1:0] rut,
                                       input logic [CNT_W-1:0] rt);
        t_plan_row row;
        row = '{kind: ROW_PULSE, calib: '0, fsec: '0, fnsec: '0,
                pulse: '{sec: s, nsec: ns, consumer_read: rd}, known: 1'b1, want: '0};
        row.want.published      = 1'b1;
        row.want.receive_sec    = rsec;
        row.want.receive_usec   = usec;
        row.want.pulse_sec      = psec;
        row.want.rounded_up     = up;
        row.want.round_up_total = rut;
        row.want.read_total     = rt;
        plan.push_back(row);
    endfunction

    function automatic t_pulse rand_pulse();
        t_pulse p;
        case ($urandom_range(0, 3))
            0: p.sec = SEC_W'($urandom_range(0, 3));
            1: p.sec = SEC_TOP - SEC_W'($urandom_range(0, 3));
            default: p.sec = {8'($urandom_range(0, 255)), $urandom};
        endcase
        case ($urandom_range(0, 7))
            0: p.nsec = NSEC_W'($urandom_range(0, 2));
            1: p.nsec = NSEC_W'(999999999 - $urandom_range(0, 2));
            2: p.nsec = NSEC_W'(499999999 + $urandom_range(0, 2));
            3: p.nsec = NSEC_W'($urandom_range(1000000000, NSEC_TOP));
            default: p.nsec = NSEC_W'($urandom_range(0, 999999999));
        endcase
        p.consumer_read = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic logic [31:0] rand_fsec();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_fnsec();
        logic [31:0] raw;
        int          v;
        if ($urandom_range(0, 3) == 0) begin
            raw = $urandom;
            return {raw[FNSEC_W-1], raw[FNSEC_W-1:0]};
        end
        v = int'($urandom_range(0, 1999999998)) - 999999999;
        return 32'(v);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CALIB_PULSES: cal_target = data[CALIB_W-1:0];
            CFG_FUDGE_SEC:    trim_sec   = data[FSEC_W-1:0];
            CFG_FUDGE_NSEC:   trim_nsec  = data[FNSEC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [CALIB_W-1:0] cp, input logic [31:0] fs,
                               input logic [31:0] fn);
        write_reg(CFG_CALIB_PULSES, {{(CFG_DATA_W-CALIB_W){1'b0}}, cp});
        write_reg(CFG_FUDGE_SEC, fs);
        write_reg(CFG_FUDGE_NSEC, fn);
        i_cfg_we <= 1'b0;
    endtask

    // drop valid and wait for every outstanding beat
    task automatic settle();
        in_if.valid <= 1'b0;
        while (aligned_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pulse(input t_pulse p, input logic known, input t_out_beat want);
        int        gap;
        t_out_beat calc;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.stamp_sec     <= p.sec;
        in_if.stamp_nsec    <= p.nsec;
        in_if.consumer_read <= p.consumer_read;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        calc = align_pulse(p);
        aligned_q.push_back(known ? want : calc);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            bad_fields++;
            if (bad_fields <= 10) begin
                $display("beat %0d %s: expected %h, got %h", beat_idx, name, want, got);
            end
        end
    endtask

    initial begin : ready_drive
        int n;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                out_if.ready <= 1'b0;
                n = hold_len;
                hold_len = 0;
                repeat (n - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : beat_check
        t_out_beat want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (aligned_q.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 10) begin
                    $display("beat %0d: unexpected beat", beat_idx);
                end
            end else begin
                want = aligned_q.pop_front();
                check_field("published", 64'(want.published), 64'(out_if.published));
                check_field("receive_sec", 64'(want.receive_sec),
                            64'(out_if.receive_sec));
                check_field("receive_usec", 64'(want.receive_usec),
                            64'(out_if.receive_usec));
                check_field("pulse_sec", 64'(want.pulse_sec), 64'(out_if.pulse_sec));
                check_field("rounded_up", 64'(want.rounded_up), 64'(out_if.rounded_up));
                check_field("round_up_total", 64'(want.round_up_total),
                            64'(out_if.round_up_total));
                check_field("read_total", 64'(want.read_total),
                            64'(out_if.read_total));
            end
            beat_idx++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1)
                || (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", quiet_cycles);
            $display("pps_edge_timestamp_aligner: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int               ph;
        int               k;
        int               n;
        int               r;
        logic [CALIB_W-1:0] cp;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.stamp_sec     = '0;
        in_if.stamp_nsec    = '0;
        in_if.consumer_read = 1'b0;

        // directed: zero correction first, then correction extremes, then calibration
        plan_known(0, 0, 0, 0, 0, 0, 0, 0, 0);
        plan_known(SEC_TOP, 999999999, 1, SEC_TOP, 999999, 0, 1, 1, 1);
        plan_known(5, 499999999, 0, 5, 499999, 5, 0, 1, 1);
        plan_known(5, 500000000, 1, 5, 500000, 6, 1, 2, 2);
        plan_known(SEC_TOP, NSEC_TOP, 0, 0, 73741, 0, 0, 2, 2);
        plan_cfg(0, 32'hFFFF_FFFF, -999999999);
        plan_pulse(0, 0, 1);
        plan_cfg(0, 32'h7FFF_FFFF, 999999999);
        plan_pulse(SEC_TOP, 999999999, 0);
        plan_cfg(0, 32'h8000_0000, -1073741824);
        plan_pulse(0, 0, 1);
        plan_pulse(123456789, 999999999, 0);
        plan_cfg(0, 0, 1073741823);
        plan_pulse(SEC_TOP, NSEC_TOP, 1);
        plan_cfg(16'hFFFF, 17, -250000000);
        plan_pulse(1000, 300000000, 1);
        plan_pulse(1001, NSEC_TOP, 0);
        // lowered below the pulses summed so far: no average, fudge stays
        plan_cfg(1, 17, -250000000);
        plan_pulse(2000, 600000000, 1);
        plan_pulse(2001, 0, 0);
        // raised again: summing resumes into the same sum
        plan_cfg(16'hFFFF, -3, 499999999);
        plan_pulse(2002, 999999999, 1);
        plan_cfg(0, -3, 499999999);
        plan_pulse(2003, 500000000, 0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                load_config(plan[i].calib, plan[i].fsec, plan[i].fnsec);
            end else begin
                send_pulse(plan[i].pulse, plan[i].known, plan[i].want);
            end
        end

        // random: early phases use the fudge or just sum, later ones calibrate
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (ph < 9) begin
                r = $urandom_range(0, 5);
                if (r == 3) begin
                    cp = 16'hFFFF;
                end else if (r == 4) begin
                    cp = CALIB_W'($urandom_range(0, cal_count));
                end else begin
                    cp = '0;
                end
            end else begin
                cp = (cal_count > 16'hFFF0) ? 16'hFFFF
                                            : cal_count + 16'($urandom_range(1, 6));
            end
            load_config(cp, rand_fsec(), rand_fnsec());
            idle_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (ph == 4) begin
                hold_len = HOLD_LEN;
            end
            n = $urandom_range(85, 115);
            for (k = 0; k < n; k++) begin
                if (ph == 6 && k == n / 2) begin
                    settle();
                end
                send_pulse(rand_pulse(), 1'b0, '0);
            end
        end

        settle();
        repeat (60) @(posedge i_clk);
        if (bad_fields == 0 && aligned_q.size() == 0) begin
            $display("pps_edge_timestamp_aligner: match");
        end else begin
            $display("pps_edge_timestamp_aligner: mismatch");
        end
        $finish;
    end

endmodule
